[rtl/core/ptc_pkg.sv]
// ---------------------------------------------------------------------------
// ptc_pkg: pressure / temperature compensation shared definitions
// Types, register indexes and fixed constants used across the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

   // raw reading and configuration port widths
   localparam int unsigned RawWidth      = 20;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 64;

   // formula constants
   localparam int unsigned FineOffset = 128000;
   localparam int unsigned PressFull  = 1048576;
   localparam int unsigned PressScale = 3125;
   localparam int unsigned RoundHalf  = 128;

   // one quotient bit per restoring divider stage
   localparam int unsigned DivSteps = 64;

   // configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TEMP_CALIB  = 2'd0,
      CSR_PRESS_LOW   = 2'd1,
      CSR_PRESS_MID   = 2'd2,
      CSR_PRESS_HIGH  = 2'd3
   } csr_index_type;

   // temperature calibration words
   typedef struct packed {
      logic [15:0] t3;
      logic [15:0] t2;
      logic [15:0] t1;
   } temp_calib_type;

   // pressure calibration words
   typedef struct packed {
      logic [15:0] p9;
      logic [15:0] p8;
      logic [15:0] p7;
      logic [15:0] p6;
      logic [15:0] p5;
      logic [15:0] p4;
      logic [15:0] p3;
      logic [15:0] p2;
      logic [15:0] p1;
   } press_calib_type;

   // temperature results carried alongside the pressure path
   typedef struct packed {
      logic [31:0] fine;
      logic [31:0] centi;
   } temp_result_type;

   // divider side data
   typedef struct packed {
      temp_result_type tres;
      logic            neg;
      logic            zero;
   } div_side_type;

endpackage

`default_nettype wire

[rtl/core/pressure_temperature_compensation_top.sv]
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_top: sensor compensation pipeline
// Integer temperature and pressure compensation of raw 20-bit readings.
// ---------------------------------------------------------------------------
// One pair of raw readings is taken per clock unless held; one result comes
// out per reading, in order, after 5 temperature stages, 7 pressure polynomial
// stages, a 65-stage divider (a sign stage, then one quotient bit per stage)
// and 8 correction stages ending in the result register. The whole pipeline
// holds while a finished result is stalled; req_stall follows rsp_stall then.
// Calibration words may be written only while no transaction is in flight.
`default_nettype none

module pressure_temperature_compensation_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // input channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [ptc_pkg::RawWidth-1:0]          req_temp_reading,
   input  wire logic [ptc_pkg::RawWidth-1:0]          req_raw_pressure,
   // result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [31:0]                         rsp_fine_temperature,
   output logic signed [31:0]                         rsp_temperature_centi,
   output logic [31:0]                                rsp_pressure_q24_8,
   output logic                                       rsp_pressure_valid,
   // configuration port
   input  wire logic                                  csr_write_enable,
   input  wire logic [ptc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire logic [ptc_pkg::CsrDataWidth-1:0]      csr_write_data
);

   logic [47:0] temp_calib_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_mid_ff;
   logic [15:0] press_high_ff;

   ptc_pkg::temp_calib_type  tcal;
   ptc_pkg::press_calib_type pcal;

   logic en;

   logic                     t_valid;
   ptc_pkg::temp_result_type t_tres;
   logic signed [33:0]       t_v1;
   logic [ptc_pkg::RawWidth-1:0] t_rp;

   logic                     p_valid;
   ptc_pkg::temp_result_type p_tres;
   logic [63:0]              p_num;
   logic [30:0]              p_den;

   logic                     d_valid;
   ptc_pkg::div_side_type    d_side;
   logic [63:0]              d_quot;

   logic [31:0] o_fine;
   logic [31:0] o_centi;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_low_ff  <= '0;
         press_mid_ff  <= '0;
         press_high_ff <= '0;
      end else if (csr_write_enable) begin
         case (ptc_pkg::csr_index_type'(csr_index))
            ptc_pkg::CSR_TEMP_CALIB: begin
               temp_calib_ff <= csr_write_data[47:0];
            end
            ptc_pkg::CSR_PRESS_LOW: begin
               press_low_ff <= csr_write_data;
            end
            ptc_pkg::CSR_PRESS_MID: begin
               press_mid_ff <= csr_write_data;
            end
            ptc_pkg::CSR_PRESS_HIGH: begin
               press_high_ff <= csr_write_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   // calibration word unpacking
   assign tcal = ptc_pkg::temp_calib_type'(temp_calib_ff);
   assign pcal = ptc_pkg::press_calib_type'({press_high_ff, press_mid_ff, press_low_ff});

   // pipeline advance: hold everything while the result is stalled
   assign en        = ~(rsp_valid & rsp_stall);
   assign req_stall = ~en;

   ptc_temp u_temp (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (req_valid),
      .temp_reading     (req_temp_reading),
      .raw_pressure     (req_raw_pressure),
      .calib            (tcal),
      .out_valid        (t_valid),
      .out_tres         (t_tres),
      .out_v1           (t_v1),
      .out_raw_pressure (t_rp)
   );

   ptc_poly u_poly (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (t_valid),
      .in_tres         (t_tres),
      .in_v1           (t_v1),
      .in_raw_pressure (t_rp),
      .calib           (pcal),
      .out_valid       (p_valid),
      .out_tres        (p_tres),
      .out_num         (p_num),
      .out_den         (p_den)
   );

   ptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_tres   (p_tres),
      .in_num    (p_num),
      .in_den    (p_den),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_quot  (d_quot)
   );

   ptc_post u_post (
      .clock              (clock),
      .reset              (reset),
      .en                 (en),
      .in_valid           (d_valid),
      .in_side            (d_side),
      .in_quot            (d_quot),
      .calib              (pcal),
      .out_valid          (rsp_valid),
      .out_fine           (o_fine),
      .out_centi          (o_centi),
      .out_pressure       (rsp_pressure_q24_8),
      .out_pressure_valid (rsp_pressure_valid)
   );

   assign rsp_fine_temperature  = $signed(o_fine);
   assign rsp_temperature_centi = $signed(o_centi);

endmodule

`default_nettype wire

[rtl/core/ptc_temp.sv]
// ---------------------------------------------------------------------------
// ptc_temp: temperature polynomial stages
// Five register stages giving fine temperature, centidegrees and the
// offset fine term that feeds the pressure polynomial.
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_temp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire logic [ptc_pkg::RawWidth-1:0]     temp_reading,
   input  wire logic [ptc_pkg::RawWidth-1:0]     raw_pressure,
   input  wire ptc_pkg::temp_calib_type          calib,
   output logic                                  out_valid,
   output ptc_pkg::temp_result_type              out_tres,
   output logic signed [33:0]                    out_v1,
   output logic [ptc_pkg::RawWidth-1:0]          out_raw_pressure
);

   logic [4:0] valid_ff;
   logic [4:0] valid_in;

   logic [31:0] t2x;
   logic [31:0] t3x;

   logic [31:0] a_in, a_ff, d_in, d_ff;
   logic [31:0] m1_in, m1_ff, dd_in, dd_ff;
   logic [31:0] dd_sh;
   logic [31:0] tv1_in, tv1_ff, m2_in, m2_ff;
   logic [31:0] fine_in, fine_ff;
   logic [31:0] sum5;
   logic [31:0] centi_in, centi_ff, fine5_ff;
   logic signed [33:0] v1_in, v1_ff;
   logic [ptc_pkg::RawWidth-1:0] rp_ff [0:4];

   assign t2x = 32'($signed(calib.t2));
   assign t3x = 32'($signed(calib.t3));

   // stage 1: offset differences
   assign a_in = 32'(temp_reading >> 3) - (32'(calib.t1) << 1);
   assign d_in = 32'(temp_reading >> 4) - 32'(calib.t1);

   // stage 2: products
   assign m1_in = a_ff * t2x;
   assign dd_in = d_ff * d_ff;

   // stage 3: linear term and quadratic scaling
   assign tv1_in = 32'($signed(m1_ff) >>> 11);
   assign dd_sh  = 32'($signed(dd_ff) >>> 12);
   assign m2_in  = dd_sh * t3x;

   // stage 4: fine temperature
   assign fine_in = tv1_ff + 32'($signed(m2_ff) >>> 14);

   // stage 5: centidegrees and pressure offset term
   assign sum5     = (fine_ff << 2) + fine_ff + 32'(ptc_pkg::RoundHalf);
   assign centi_in = 32'($signed(sum5) >>> 8);
   assign v1_in    = 34'($signed(fine_ff)) - 34'(ptc_pkg::FineOffset);

   assign valid_in = {valid_ff[3:0], in_valid};

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         d_ff     <= d_in;
         m1_ff    <= m1_in;
         dd_ff    <= dd_in;
         tv1_ff   <= tv1_in;
         m2_ff    <= m2_in;
         fine_ff  <= fine_in;
         centi_ff <= centi_in;
         fine5_ff <= fine_ff;
         v1_ff    <= v1_in;
         rp_ff[0] <= raw_pressure;
         rp_ff[1] <= rp_ff[0];
         rp_ff[2] <= rp_ff[1];
         rp_ff[3] <= rp_ff[2];
         rp_ff[4] <= rp_ff[3];
      end
   end

   assign out_valid        = valid_ff[4];
   assign out_tres.fine    = fine5_ff;
   assign out_tres.centi   = centi_ff;
   assign out_v1           = v1_ff;
   assign out_raw_pressure = rp_ff[4];

endmodule

`default_nettype wire

[rtl/core/ptc_poly.sv]
// ---------------------------------------------------------------------------
// ptc_poly: pressure polynomial stages
// Seven register stages building the division numerator and divisor from
// the offset fine term, with wide products split into 32-bit partials.
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_poly (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire ptc_pkg::temp_result_type         in_tres,
   input  wire logic signed [33:0]               in_v1,
   input  wire logic [ptc_pkg::RawWidth-1:0]     in_raw_pressure,
   input  wire ptc_pkg::press_calib_type         calib,
   output logic                                  out_valid,
   output ptc_pkg::temp_result_type              out_tres,
   output logic [63:0]                           out_num,
   output logic [30:0]                           out_den
);

   logic [6:0] valid_ff;
   logic [6:0] valid_in;

   ptc_pkg::temp_result_type tres_ff [0:6];
   logic [ptc_pkg::RawWidth-1:0] rp_ff [0:2];

   // stage 1
   logic signed [67:0] sq_full;
   logic [62:0]        sq_ff;
   logic signed [49:0] v1p5_in, v1p5_ff [0:2];
   logic signed [49:0] v1p2_in, v1p2_ff [0:2];
   // stage 2
   logic signed [48:0] pl6_in, pl6_ff, pl3_in, pl3_ff;
   logic [31:0]        ph6_in, ph6_ff, ph3_in, ph3_ff;
   // stage 3
   logic [63:0]        t6_in, t6_ff, t3_in, t3_ff;
   // stage 4
   logic [63:0]        v2_in, v2_ff;
   logic [63:0]        v1b_in, v1b_ff;
   logic [20:0]        praw_in, praw_ff;
   // stage 5
   logic [63:0]        wb_in, wb_ff, nb_in, nb_ff;
   // stage 6
   logic [47:0]        wl_in, wl_ff;
   logic [31:0]        wh_in, wh_ff;
   logic [43:0]        nl_in, nl_ff;
   logic [31:0]        nh_in, nh_ff;
   // stage 7
   logic [63:0]        wp;
   logic [63:0]        num_in, num_ff;
   logic [30:0]        den_ff;

   // stage 1: square and linear products of the offset term
   assign sq_full = in_v1 * in_v1;
   assign v1p5_in = in_v1 * $signed(calib.p5);
   assign v1p2_in = in_v1 * $signed(calib.p2);

   // stage 2: square times p6 and p3, low and high partials
   assign pl6_in = $signed({1'b0, sq_ff[31:0]}) * $signed(calib.p6);
   assign pl3_in = $signed({1'b0, sq_ff[31:0]}) * $signed(calib.p3);
   assign ph6_in = {1'b0, sq_ff[62:32]} * 32'($signed(calib.p6));
   assign ph3_in = {1'b0, sq_ff[62:32]} * 32'($signed(calib.p3));

   // stage 3: combine partials
   assign t6_in = 64'(pl6_ff) + {ph6_ff, 32'b0};
   assign t3_in = 64'(pl3_ff) + {ph3_ff, 32'b0};

   // stage 4: var2 and var1 sums, pressure complement
   assign v2_in   = t6_ff + (64'(v1p5_ff[2]) << 17) + (64'($signed(calib.p4)) << 35);
   assign v1b_in  = 64'($signed(t3_ff) >>> 8) + (64'(v1p2_ff[2]) << 12);
   assign praw_in = 21'(ptc_pkg::PressFull) - {1'b0, rp_ff[2]};

   // stage 5: offset var1 and shifted numerator base
   assign wb_in = v1b_ff + (64'd1 << 47);
   assign nb_in = {12'b0, praw_ff, 31'b0} - v2_ff;

   // stage 6: scale partials
   assign wl_in = 48'(wb_ff[31:0]) * 48'(calib.p1);
   assign wh_in = wb_ff[63:32] * 32'(calib.p1);
   assign nl_in = 44'(nb_ff[31:0]) * 44'(ptc_pkg::PressScale);
   assign nh_in = nb_ff[63:32] * 32'(ptc_pkg::PressScale);

   // stage 7: divisor and numerator
   assign wp     = 64'(wl_ff) + {wh_ff, 32'b0};
   assign num_in = 64'(nl_ff) + {nh_ff, 32'b0};

   assign valid_in = {valid_ff[5:0], in_valid};

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en) begin
         tres_ff[0] <= in_tres;
         for (int i = 1; i < 7; i++) begin
            tres_ff[i] <= tres_ff[i-1];
         end
         rp_ff[0]   <= in_raw_pressure;
         rp_ff[1]   <= rp_ff[0];
         rp_ff[2]   <= rp_ff[1];
         sq_ff      <= sq_full[62:0];
         v1p5_ff[0] <= v1p5_in;
         v1p5_ff[1] <= v1p5_ff[0];
         v1p5_ff[2] <= v1p5_ff[1];
         v1p2_ff[0] <= v1p2_in;
         v1p2_ff[1] <= v1p2_ff[0];
         v1p2_ff[2] <= v1p2_ff[1];
         pl6_ff     <= pl6_in;
         pl3_ff     <= pl3_in;
         ph6_ff     <= ph6_in;
         ph3_ff     <= ph3_in;
         t6_ff      <= t6_in;
         t3_ff      <= t3_in;
         v2_ff      <= v2_in;
         v1b_ff     <= v1b_in;
         praw_ff    <= praw_in;
         wb_ff      <= wb_in;
         nb_ff      <= nb_in;
         wl_ff      <= wl_in;
         wh_ff      <= wh_in;
         nl_ff      <= nl_in;
         nh_ff      <= nh_in;
         num_ff     <= num_in;
         den_ff     <= wp[63:33];
      end
   end

   assign out_valid = valid_ff[6];
   assign out_tres  = tres_ff[6];
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

`default_nettype wire

[rtl/core/ptc_div.sv]
// ---------------------------------------------------------------------------
// ptc_div: pipelined signed divider
// A sign stage followed by one restoring quotient bit per register stage.
// Produces the quotient magnitude, the result sign and a zero-divisor flag.
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire ptc_pkg::temp_result_type  in_tres,
   input  wire logic [63:0]               in_num,
   input  wire logic [30:0]               in_den,
   output logic                           out_valid,
   output ptc_pkg::div_side_type          out_side,
   output logic [63:0]                    out_quot
);

   localparam int unsigned Steps = ptc_pkg::DivSteps;

   logic                  valid_ff [0:Steps];
   logic [30:0]           rem_ff   [0:Steps];
   logic [63:0]           q_ff     [0:Steps];
   logic [30:0]           ad_ff    [0:Steps];
   ptc_pkg::div_side_type side_ff  [0:Steps];

   ptc_pkg::div_side_type side_in;
   logic [63:0]           an_in;
   logic [30:0]           ad_in;

   // sign stage: magnitudes and flags
   assign an_in        = in_num[63] ? (64'd0 - in_num) : in_num;
   assign ad_in        = in_den[30] ? (31'd0 - in_den) : in_den;
   assign side_in.tres = in_tres;
   assign side_in.neg  = in_num[63] ^ in_den[30];
   assign side_in.zero = (in_den == 31'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         q_ff[0]    <= an_in;
         ad_ff[0]   <= ad_in;
         side_ff[0] <= side_in;
      end
   end

   // restoring steps, most significant quotient bit first
   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic [31:0] trial;
      logic [31:0] diff;
      logic        ge;

      assign trial = {rem_ff[k], q_ff[k][63]};
      assign diff  = trial - {1'b0, ad_ff[k]};
      assign ge    = (trial >= {1'b0, ad_ff[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? diff[30:0] : trial[30:0];
            q_ff[k+1]    <= {q_ff[k][62:0], ge};
            ad_ff[k+1]   <= ad_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_side  = side_ff[Steps];
   assign out_quot  = q_ff[Steps];

endmodule

`default_nettype wire

[rtl/core/ptc_post.sv]
// ---------------------------------------------------------------------------
// ptc_post: pressure correction and output stages
// Eight register stages applying the p7..p9 correction to the quotient and
// saturating the result; the last stage is the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_post (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire ptc_pkg::div_side_type     in_side,
   input  wire logic [63:0]               in_quot,
   input  wire ptc_pkg::press_calib_type  calib,
   output logic                           out_valid,
   output logic [31:0]                    out_fine,
   output logic [31:0]                    out_centi,
   output logic [31:0]                    out_pressure,
   output logic                           out_pressure_valid
);

   logic [7:0] valid_ff;
   logic [7:0] valid_in;

   ptc_pkg::temp_result_type tres_ff [0:7];
   logic                     zero_ff [0:6];
   logic [63:0]              p_ff    [0:4];

   // stage 1
   logic [63:0]        p_in, ps_in, ps_ff;
   // stage 2
   logic [63:0]        ll_in, ll_ff;
   logic [31:0]        cr_in, cr_ff;
   logic signed [48:0] pl8_in, pl8_ff;
   logic [31:0]        ph8_in, ph8_ff;
   // stage 3
   logic [63:0]        sq2_in, sq2_ff, w2full, w2_in;
   logic [63:0]        w2_ff [0:2];
   // stage 4
   logic signed [48:0] ql_in, ql_ff;
   logic [31:0]        qh_in, qh_ff;
   // stage 5
   logic [63:0]        w1full, w1_in, w1_ff;
   // stage 6
   logic [63:0]        s0_in, s0_ff;
   // stage 7
   logic [63:0]        fin_in, fin_ff;
   // stage 8
   logic [31:0]        press_in, press_ff;
   logic               pvalid_ff;

   // stage 1: signed quotient and its coarse copy
   assign p_in  = in_side.neg ? (64'd0 - in_quot) : in_quot;
   assign ps_in = 64'($signed(p_in) >>> 13);

   // stage 2: square partials and p8 partials
   assign ll_in  = 64'(ps_ff[31:0]) * 64'(ps_ff[31:0]);
   assign cr_in  = ps_ff[31:0] * ps_ff[63:32];
   assign pl8_in = $signed({1'b0, p_ff[0][31:0]}) * $signed(calib.p8);
   assign ph8_in = p_ff[0][63:32] * 32'($signed(calib.p8));

   // stage 3: square and var2 term
   assign sq2_in = ll_ff + {cr_ff[30:0], 1'b0, 32'b0};
   assign w2full = 64'(pl8_ff) + {ph8_ff, 32'b0};
   assign w2_in  = 64'($signed(w2full) >>> 19);

   // stage 4: square times p9 partials
   assign ql_in = $signed({1'b0, sq2_ff[31:0]}) * $signed(calib.p9);
   assign qh_in = sq2_ff[63:32] * 32'($signed(calib.p9));

   // stage 5: var1 term
   assign w1full = 64'(ql_ff) + {qh_ff, 32'b0};
   assign w1_in  = 64'($signed(w1full) >>> 25);

   // stage 6: sum of terms
   assign s0_in = p_ff[4] + w1_ff + w2_ff[2];

   // stage 7: scale and p7 offset
   assign fin_in = 64'($signed(s0_ff) >>> 8) + (64'($signed(calib.p7)) << 4);

   // stage 8: saturation
   always_comb begin
      if (zero_ff[6] || fin_ff[63]) begin
         press_in = 32'd0;
      end else if (fin_ff[63:32] != 32'd0) begin
         press_in = 32'hFFFF_FFFF;
      end else begin
         press_in = fin_ff[31:0];
      end
   end

   assign valid_in = {valid_ff[6:0], in_valid};

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (en) begin
         tres_ff[0] <= in_side.tres;
         zero_ff[0] <= in_side.zero;
         for (int i = 1; i < 8; i++) begin
            tres_ff[i] <= tres_ff[i-1];
         end
         for (int i = 1; i < 7; i++) begin
            zero_ff[i] <= zero_ff[i-1];
         end
         p_ff[0] <= p_in;
         for (int i = 1; i < 5; i++) begin
            p_ff[i] <= p_ff[i-1];
         end
         ps_ff     <= ps_in;
         ll_ff     <= ll_in;
         cr_ff     <= cr_in;
         pl8_ff    <= pl8_in;
         ph8_ff    <= ph8_in;
         sq2_ff    <= sq2_in;
         w2_ff[0]  <= w2_in;
         w2_ff[1]  <= w2_ff[0];
         w2_ff[2]  <= w2_ff[1];
         ql_ff     <= ql_in;
         qh_ff     <= qh_in;
         w1_ff     <= w1_in;
         s0_ff     <= s0_in;
         fin_ff    <= fin_in;
         press_ff  <= press_in;
         pvalid_ff <= ~zero_ff[6];
      end
   end

   assign out_valid          = valid_ff[7];
   assign out_fine           = tres_ff[7].fine;
   assign out_centi          = tres_ff[7].centi;
   assign out_pressure       = press_ff;
   assign out_pressure_valid = pvalid_ff;

endmodule

`default_nettype wire

[dv/ptc_checker.sv]
// ---------------------------------------------------------------------------
// ptc_checker: compensation result predictor and scoreboard
// Watches both channels, predicts each result from the calibration words
// and compares the result channel field by field in order.
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [19:0] req_temp_reading,
   input  wire logic [19:0] req_raw_pressure,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_fine_temperature,
   input  wire logic [31:0] rsp_temperature_centi,
   input  wire logic [31:0] rsp_pressure_q24_8,
   input  wire logic        rsp_pressure_valid,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_write_data,
   output int               error_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] fine;
      logic [31:0] centi;
      logic [31:0] press;
      logic        pvalid;
   } comp_result_type;

   logic [47:0] temp_words;
   logic [63:0] press_low_words, press_mid_words;
   logic [15:0] press_high_word;
   comp_result_type expected_results[$];

   assign pending_count = expected_results.size();

   function automatic logic signed [63:0] sx16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // compute the compensated reading with 32-bit temperature, 64-bit pressure wrap
   function automatic comp_result_type compensate(logic [19:0] adc_t, logic [19:0] adc_p);
      comp_result_type r;
      logic signed [31:0] t1, t2, t3, a, d, tv1, tv2, fine, dd;
      logic signed [63:0] v1, v2, p, ps, w1, w2, num, an, ad, q;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic neg;
      t1 = {16'd0, temp_words[15:0]};
      t2 = {{16{temp_words[31]}}, temp_words[31:16]};
      t3 = {{16{temp_words[47]}}, temp_words[47:32]};
      a = {15'd0, adc_t[19:3]} - (t1 <<< 1);
      tv1 = (a * t2) >>> 11;
      d = {16'd0, adc_t[19:4]} - t1;
      dd = (d * d) >>> 12;
      tv2 = (dd * t3) >>> 14;
      fine = tv1 + tv2;
      r.fine = fine;
      r.centi = (fine * 32'sd5 + 32'sd128) >>> 8;
      p1 = {48'd0, press_low_words[15:0]};
      p2 = sx16(press_low_words[31:16]);
      p3 = sx16(press_low_words[47:32]);
      p4 = sx16(press_low_words[63:48]);
      p5 = sx16(press_mid_words[15:0]);
      p6 = sx16(press_mid_words[31:16]);
      p7 = sx16(press_mid_words[47:32]);
      p8 = sx16(press_mid_words[63:48]);
      p9 = sx16(press_high_word);
      v1 = {{32{fine[31]}}, fine} - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      r.press = '0;
      r.pvalid = 1'b0;
      if (v1 != 0) begin
         p = 64'sd1048576 - {44'd0, adc_p};
         num = ((p <<< 31) - v2) * 64'sd3125;
         neg = num[63] ^ v1[63];
         an = num[63] ? -num : num;
         ad = v1[63] ? -v1 : v1;
         q = $signed($unsigned(an) / $unsigned(ad));
         p = neg ? -q : q;
         ps = p >>> 13;
         w1 = (p9 * ps * ps) >>> 25;
         w2 = (p8 * p) >>> 19;
         p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
         if (p[63]) r.press = '0;
         else if (p > 64'sh0_FFFF_FFFF) r.press = 32'hFFFF_FFFF;
         else r.press = p[31:0];
         r.pvalid = 1'b1;
      end
      return r;
   endfunction

   // track calibration, predict on request, compare on response
   always @(posedge clock) begin
      comp_result_type got, exp_r;
      if (reset) begin
         temp_words <= '0;
         press_low_words <= '0;
         press_mid_words <= '0;
         press_high_word <= '0;
         error_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               ptc_pkg::CSR_TEMP_CALIB: temp_words <= csr_write_data[47:0];
               ptc_pkg::CSR_PRESS_LOW:  press_low_words <= csr_write_data;
               ptc_pkg::CSR_PRESS_MID:  press_mid_words <= csr_write_data;
               ptc_pkg::CSR_PRESS_HIGH: press_high_word <= csr_write_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_results.push_back(compensate(req_temp_reading, req_raw_pressure));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_fine_temperature, rsp_temperature_centi, rsp_pressure_q24_8,
                   rsp_pressure_valid};
            if (expected_results.size() == 0) begin
               if (error_count < 10) $display("unexpected transaction %h", got);
               error_count <= error_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  if (error_count < 10)
                     $display({"mismatch: fine exp %h got %h, centi exp %h got %h, ",
                               "press exp %h got %h, valid exp %b got %b"},
                              exp_r.fine, got.fine, exp_r.centi, got.centi,
                              exp_r.press, got.press, exp_r.pvalid, got.pvalid);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: compensation pipeline testbench
// Drives calibration phases and raw readings with random gaps and stalls,
// and gives the verdict from the checker's error count and an idle watchdog.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = 85;
   localparam int WatchLimit = 4000;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic [19:0] req_temp_reading, req_raw_pressure;
   logic [31:0] rsp_fine_temperature, rsp_temperature_centi, rsp_pressure_q24_8;
   logic rsp_pressure_valid, csr_write_enable;
   logic [1:0] csr_index;
   logic [63:0] csr_write_data;
   int error_count, pending_count, idle_cycles;

   pressure_temperature_compensation_top DUT (.*);
   ptc_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // receiver stalls: random gap per result, with quiet stretches
   initial begin
      int gap;
      rsp_stall <= 1'b1;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         repeat (gap) begin rsp_stall <= 1'b1; @(posedge clock); end
         rsp_stall <= 1'b0;
         @(posedge clock iff rsp_valid);
      end
   end

   task automatic write_csr(ptc_pkg::csr_index_type idx, logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain_pipe();
      while (pending_count != 0) @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
   endtask

   task automatic send_reading(logic [19:0] t, logic [19:0] p, bit quiet);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_temp_reading <= t;
      req_raw_pressure <= p;
      @(posedge clock iff !req_stall);
   endtask

   function automatic logic [19:0] rand_raw();
      case ($urandom_range(0, 5))
         0: return 20'h0;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   // a typical calibration set, with random perturbation when jitter is set
   task automatic load_typical(bit jitter);
      logic [15:0] j;
      j = jitter ? 16'($urandom_range(0, 255)) : 16'd0;
      write_csr(ptc_pkg::CSR_TEMP_CALIB,
                64'({16'hFC18, 16'd26435 + j, 16'd27504 + j}));
      write_csr(ptc_pkg::CSR_PRESS_LOW, {16'd2855, 16'hEE6D, 16'hD6E0, 16'd36477 + j});
      write_csr(ptc_pkg::CSR_PRESS_MID, {16'hC6F0, 16'd15500, 16'hFFF9, 16'd140});
      write_csr(ptc_pkg::CSR_PRESS_HIGH, 64'd6000);
   endtask

   initial begin
      bit quiet;
      req_valid <= 1'b0;
      req_temp_reading <= '0;
      req_raw_pressure <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= ptc_pkg::CSR_TEMP_CALIB;
      csr_write_data <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: zero divisor everywhere
      send_reading(20'h0, 20'hFFFFF, 0);
      send_reading(20'hFFFFF, 20'h0, 0);
      req_valid <= 1'b0;
      drain_pipe();

      // typical calibration, directed extremes
      load_typical(0);
      send_reading(20'h0, 20'h0, 0);
      send_reading(20'hFFFFF, 20'hFFFFF, 0);
      send_reading(20'h80000, 20'h51000, 0);
      send_reading(20'h7EF00, 20'h65000, 0);
      send_reading(20'hAAAAA, 20'h55555, 0);
      send_reading(20'h55555, 20'hAAAAA, 0);
      req_valid <= 1'b0;
      drain_pipe();

      // extreme calibration words: all ones, then min/max mixes
      write_csr(ptc_pkg::CSR_TEMP_CALIB, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(ptc_pkg::CSR_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(ptc_pkg::CSR_PRESS_MID, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(ptc_pkg::CSR_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int i = 0; i < 4; i++) send_reading(rand_raw(), rand_raw(), 0);
      req_valid <= 1'b0;
      drain_pipe();
      write_csr(ptc_pkg::CSR_TEMP_CALIB, 64'({16'h7FFF, 16'h8000, 16'hFFFF}));
      write_csr(ptc_pkg::CSR_PRESS_LOW, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
      write_csr(ptc_pkg::CSR_PRESS_MID, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
      write_csr(ptc_pkg::CSR_PRESS_HIGH, 64'h8000);
      for (int i = 0; i < 4; i++) send_reading(rand_raw(), rand_raw(), 0);
      req_valid <= 1'b0;
      drain_pipe();

      // random phases: mostly realistic calibration, some fully random
      for (int ph = 0; ph < 17; ph++) begin
         if (ph % 3 == 2) begin
            write_csr(ptc_pkg::CSR_TEMP_CALIB, {$urandom, $urandom});
            write_csr(ptc_pkg::CSR_PRESS_LOW, {$urandom, $urandom});
            write_csr(ptc_pkg::CSR_PRESS_MID, {$urandom, $urandom});
            write_csr(ptc_pkg::CSR_PRESS_HIGH, {$urandom, $urandom});
         end else load_typical(1);
         quiet = (ph % 4 == 1);
         for (int i = 0; i < 50; i++) begin
            send_reading(rand_raw(), rand_raw(), quiet);
            // hold off once until the pipeline has fully drained
            if (ph == 5 && i == 25) begin
               req_valid <= 1'b0;
               while (pending_count != 0) @(posedge clock);
            end
         end
         req_valid <= 1'b0;
         drain_pipe();
      end

      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

`default_nettype wire

[files.f]
rtl/core/ptc_pkg.sv
rtl/core/ptc_temp.sv
rtl/core/ptc_poly.sv
rtl/core/ptc_div.sv
rtl/core/ptc_post.sv
rtl/core/pressure_temperature_compensation_top.sv
dv/ptc_checker.sv
dv/tb_top.sv
